>>> sv/dte_pkg.sv
package dte_pkg;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } in_item_t;

  typedef struct packed {
    logic        date_valid;
    logic        leap_year;
    logic [4:0]  month_length;
    logic [31:0] epoch_days;
    logic [48:0] epoch_seconds;
  } out_item_t;

  localparam logic [13:0] YEAR_MIN     = 14'd2000;
  localparam logic [13:0] YEAR_MAX     = 14'd2099;
  localparam logic [31:0] DAY_OFFSET   = 32'd719591;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [16:0] SECS_PER_HR  = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN = 17'd60;
  localparam logic [8:0]  DAYS_PER_YR  = 9'd365;
  localparam logic [6:0]  CENTURY      = 7'd100;
  localparam logic [4:0]  HOUR_MAX     = 5'd23;
  localparam logic [5:0]  MIN_MAX      = 6'd59;
  localparam logic [5:0]  SEC_MAX      = 6'd59;

  // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT, exact for x < 91180
  localparam logic [16:0] DIV100_MUL   = 17'd83887;
  localparam int          DIV100_SHIFT = 23;

  // floor((m' + 1) * 153 / 5), m' = month with Jan/Feb moved to 13/14
  function automatic logic [8:0] month_term(input logic [3:0] month);
    logic [8:0] t;
    case (month)
      4'd0:    t = 9'd397;
      4'd1:    t = 9'd428;
      4'd2:    t = 9'd459;
      4'd3:    t = 9'd122;
      4'd4:    t = 9'd153;
      4'd5:    t = 9'd183;
      4'd6:    t = 9'd214;
      4'd7:    t = 9'd244;
      4'd8:    t = 9'd275;
      4'd9:    t = 9'd306;
      4'd10:   t = 9'd336;
      4'd11:   t = 9'd367;
      4'd12:   t = 9'd397;
      4'd13:   t = 9'd428;
      4'd14:   t = 9'd459;
      default: t = 9'd489;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

>>> sv/dte_sec_conv.sv
// Days plus time of day to seconds: multiply stage, then add stage.
module dte_sec_conv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        vld_in,
  input  logic [31:0] days,
  input  logic [16:0] tod,
  output logic        vld_out,
  output logic [48:0] secs
);

  logic        mul_vld_r;
  logic [48:0] prod_r;
  logic [16:0] tod_r;
  logic        sum_vld_r;
  logic [48:0] secs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      sum_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= vld_in;
      sum_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_in) begin
      prod_r <= 49'(days) * 49'(dte_pkg::SECS_PER_DAY);
      tod_r  <= tod;
    end
    if (mul_vld_r) begin
      secs_r <= prod_r + 49'(tod_r);
    end
  end

  assign vld_out = sum_vld_r;
  assign secs    = secs_r;

endmodule

>>> sv/date_to_epoch_seconds.sv
// Start runs through stages 1 and 2 and the multiply and add stages to out_strobe.
// Throughput: one transaction per cycle; busy is always low.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset (rst_n low, synchronous) clears the valid pipeline; in-flight
// transactions are dropped and no strobe follows.
module date_to_epoch_seconds (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dte_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output dte_pkg::out_item_t  out_item
);

  logic accept;

  // Stage 1: year adjust, the two divide-by-100 products, y*365, month
  // term lookup, time-of-day seconds and the simple range checks.
  logic        s1_vld_r;
  logic [15:0] s1_y_r;      // year, minus one for Jan/Feb (16-bit wrap)
  logic [24:0] s1_y365_r;
  logic [32:0] s1_yq_r;     // adjusted year * DIV100_MUL
  logic [30:0] s1_rq_r;     // raw year * DIV100_MUL, for the leap test
  logic [8:0]  s1_mterm_r;
  logic [13:0] s1_year_r;
  logic [3:0]  s1_month_r;
  logic [4:0]  s1_day_r;
  logic [16:0] s1_tod_r;
  logic        s1_yok_r;    // year in 2000..2099
  logic        s1_tok_r;    // hour, minute, second in range

  logic [15:0] y_nxt;
  logic [16:0] tod_nxt;

  // Stage 2: day sum, leap flag, month length, validity.
  logic        s2_vld_r;
  logic [31:0] s2_days_r;
  logic        s2_leap_r;
  logic [4:0]  s2_mlen_r;
  logic        s2_valid_r;
  logic [16:0] s2_tod_r;

  logic [9:0]  q100;
  logic [7:0]  rq100;
  logic [13:0] rem100;
  logic        leap_nxt;
  logic [4:0]  mlen_nxt;
  logic        valid_nxt;
  logic [31:0] days_nxt;

  // Stages 3 and 4: flags and day count ride alongside the seconds unit.
  logic        s3_leap_r;
  logic [4:0]  s3_mlen_r;
  logic        s3_valid_r;
  logic [31:0] s3_days_r;
  logic        s4_leap_r;
  logic [4:0]  s4_mlen_r;
  logic        s4_valid_r;
  logic [31:0] s4_days_r;

  logic        sec_vld;
  logic [48:0] sec_val;

  // Fully pipelined: never busy.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------------
  // Stage 1
  // ---------------------------------------------------------------------
  always_comb begin
    // Jan and Feb count as months 13 and 14 of the previous year;
    // year zero wraps to 65535 as in 16-bit arithmetic.
    if (in_item.month <= 4'd2) begin
      y_nxt = {2'b00, in_item.year} - 16'd1;
    end else begin
      y_nxt = {2'b00, in_item.year};
    end
    tod_nxt = 17'(in_item.hour) * dte_pkg::SECS_PER_HR
            + 17'(in_item.minute) * dte_pkg::SECS_PER_MIN
            + 17'(in_item.second);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_y_r     <= y_nxt;
      s1_y365_r  <= 25'(y_nxt) * 25'(dte_pkg::DAYS_PER_YR);
      s1_yq_r    <= 33'(y_nxt) * 33'(dte_pkg::DIV100_MUL);
      s1_rq_r    <= 31'(in_item.year) * 31'(dte_pkg::DIV100_MUL);
      s1_mterm_r <= dte_pkg::month_term(in_item.month);
      s1_year_r  <= in_item.year;
      s1_month_r <= in_item.month;
      s1_day_r   <= in_item.day;
      s1_tod_r   <= tod_nxt;
      s1_yok_r   <= (in_item.year >= dte_pkg::YEAR_MIN) &&
                    (in_item.year <= dte_pkg::YEAR_MAX);
      s1_tok_r   <= (in_item.hour <= dte_pkg::HOUR_MAX) &&
                    (in_item.minute <= dte_pkg::MIN_MAX) &&
                    (in_item.second <= dte_pkg::SEC_MAX);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2
  // ---------------------------------------------------------------------
  always_comb begin
    // y/100 from the reciprocal product; y/400 is (y/100)/4.
    q100   = s1_yq_r[dte_pkg::DIV100_SHIFT +: 10];
    rq100  = s1_rq_r[dte_pkg::DIV100_SHIFT +: 8];
    rem100 = s1_year_r - 14'(rq100) * 14'(dte_pkg::CENTURY);

    // Divisible by 4 and not by 100, or by 400 (century multiple of 4).
    leap_nxt = (s1_year_r[1:0] == 2'b00) &&
               ((rem100 != 14'd0) || (rq100[1:0] == 2'b00));

    mlen_nxt = dte_pkg::month_len(s1_month_r, leap_nxt);

    // A zero length marks a month outside 1..12.
    valid_nxt = s1_yok_r && s1_tok_r && (mlen_nxt != 5'd0) &&
                (s1_day_r != 5'd0) && (s1_day_r <= mlen_nxt);

    // Wraps modulo 2^32 for dates before 1970.
    days_nxt = 32'(s1_y365_r) + 32'(s1_y_r >> 2) - 32'(q100) + 32'(q100 >> 2)
             + 32'(s1_mterm_r) + 32'(s1_day_r) - dte_pkg::DAY_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_days_r  <= days_nxt;
      s2_leap_r  <= leap_nxt;
      s2_mlen_r  <= mlen_nxt;
      s2_valid_r <= valid_nxt;
      s2_tod_r   <= s1_tod_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 3 and 4: days * 86400, then add the time of day.
  // ---------------------------------------------------------------------
  dte_sec_conv u_sec_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (s2_vld_r),
    .days    (s2_days_r),
    .tod     (s2_tod_r),
    .vld_out (sec_vld),
    .secs    (sec_val)
  );

  // Payload delay matching the seconds unit; no reset needed.
  always_ff @(posedge clk) begin
    s3_leap_r  <= s2_leap_r;
    s3_mlen_r  <= s2_mlen_r;
    s3_valid_r <= s2_valid_r;
    s3_days_r  <= s2_days_r;
    s4_leap_r  <= s3_leap_r;
    s4_mlen_r  <= s3_mlen_r;
    s4_valid_r <= s3_valid_r;
    s4_days_r  <= s3_days_r;
  end

  assign out_strobe             = sec_vld;
  assign out_item.date_valid    = s4_valid_r;
  assign out_item.leap_year     = s4_leap_r;
  assign out_item.month_length  = s4_mlen_r;
  assign out_item.epoch_days    = s4_days_r;
  assign out_item.epoch_seconds = sec_val;

endmodule
